/* design/mfl_pkg.sv */
package mfl_pkg;

  // count saturation limit and derived widths
  localparam int MAX_LEN   = 1024;
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int NUM_BINS  = 52;
  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int RANK_W    = 6;
  localparam int CHAR_W    = 8;
  localparam int TOP_CNT_W = 11;

  // queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z = 8'h7a;
  localparam logic [BIN_W-1:0]  LO_BASE   = BIN_W'(26);

  // classified text byte
  typedef struct packed {
    logic              letter;
    logic [BIN_W-1:0]  bin;
    logic [CHAR_W-1:0] code;
    logic              eot;
  } item_t;

  // one histogram entry
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [CNT_W-1:0]  cnt;
  } entry_t;

  // map a byte to its letter bin
  function automatic item_t classify(input logic [CHAR_W-1:0] c, input logic eot);
    item_t it;
    it.letter = 1'b0;
    it.bin    = '0;
    it.code   = c;
    it.eot    = eot;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      it.letter = 1'b1;
      it.bin    = BIN_W'(c - CHAR_UP_A);
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      it.letter = 1'b1;
      it.bin    = BIN_W'(c - CHAR_LO_A) + LO_BASE;
    end
    return it;
  endfunction

endpackage

/* design/most_frequent_letter.sv */
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------
// in       | in_valid / in_stall  | char_code, end_of_text
// out      | out_valid/ out_stall | top_letter, top_count, letter_found
//
// one byte per cycle sustained while the counting stage does not hold; a
// 4-entry queue feeds a single counting stage that does a read-modify-write
// of the 52-bin histogram memory; a registered result follows each text.
// rst is synchronous and clears all valid bits, pointers and the leader.
// the counting stage holds only while a result waits behind out_stall;
// in_stall rises once the queue is full.
module most_frequent_letter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mfl_pkg::CHAR_W-1:0]       char_code,
  input  logic                             end_of_text,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mfl_pkg::CHAR_W-1:0]       top_letter,
  output logic [mfl_pkg::TOP_CNT_W-1:0]    top_count,
  output logic                             letter_found
);
  import mfl_pkg::*;

  logic  q_valid;
  item_t q_head;
  logic  q_pop;

  mfl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  mfl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .top_letter   (top_letter),
    .top_count    (top_count),
    .letter_found (letter_found)
  );

endmodule

/* design/mfl_front.sv */
module mfl_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mfl_pkg::CHAR_W-1:0]    char_code,
  input  logic                          end_of_text,
  output logic                          q_valid,
  output mfl_pkg::item_t                q_head,
  input  logic                          q_pop
);
  import mfl_pkg::*;

  item_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_head   = q_mem[rd_ptr];

  // classify on transfer and queue the item
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= classify(char_code, end_of_text);
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

/* design/mfl_back.sv */
module mfl_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  mfl_pkg::item_t                   q_head,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mfl_pkg::CHAR_W-1:0]       top_letter,
  output logic [mfl_pkg::TOP_CNT_W-1:0]    top_count,
  output logic                             letter_found
);
  import mfl_pkg::*;

  // histogram memory with per-entry valid bits
  entry_t              hist [NUM_BINS];
  logic [NUM_BINS-1:0] seen;

  // count stage
  logic               s1_valid;
  item_t              s1;
  entry_t             rd_data;
  logic               rd_seen;
  logic               fwd;
  entry_t             fwd_data;
  logic               cleared;

  // running leader
  logic [CHAR_W-1:0]  best_letter;
  logic [CNT_W-1:0]   best_count;
  logic [RANK_W-1:0]  best_rank;
  logic [RANK_W-1:0]  next_rank;

  logic [CHAR_W-1:0]  best_letter_next;
  logic [CNT_W-1:0]   best_count_next;
  logic [RANK_W-1:0]  best_rank_next;
  logic [RANK_W-1:0]  next_rank_next;

  entry_t             cur;
  entry_t             upd;
  logic               adv;
  logic               wr_en;
  logic               take_out;

  // stage holds only when an end-of-text result cannot leave
  assign adv   = !s1_valid || !s1.eot || !out_valid || !out_stall;
  assign q_pop = adv && q_valid;
  assign wr_en = adv && s1_valid && s1.letter && !s1.eot;

  // current entry: forwarded write, cleared table or memory
  always_comb begin
    if (fwd)                      cur = fwd_data;
    else if (cleared || !rd_seen) cur = '0;
    else                          cur = rd_data;
  end

  // rank on first sight, saturating increment, leader update
  always_comb begin
    upd              = cur;
    next_rank_next   = next_rank;
    best_letter_next = best_letter;
    best_count_next  = best_count;
    best_rank_next   = best_rank;
    if (s1_valid && s1.letter) begin
      if (cur.rank == '0) begin
        upd.rank       = next_rank;
        next_rank_next = next_rank + RANK_W'(1);
      end
      if (cur.cnt < CNT_W'(MAX_LEN)) upd.cnt = cur.cnt + CNT_W'(1);
      if (upd.cnt > best_count || (upd.cnt == best_count && upd.rank < best_rank)) begin
        best_letter_next = s1.code;
        best_count_next  = upd.cnt;
        best_rank_next   = upd.rank;
      end
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) hist[s1.bin] <= upd;
    if (adv)   rd_data <= hist[q_head.bin];
  end

  // read-side bookkeeping, forwarding of the entry being written
  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data <= upd;
      rd_seen  <= seen[q_head.bin];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
      cleared  <= 1'b0;
    end else if (adv) begin
      s1_valid <= q_valid;
      fwd      <= wr_en && (q_head.bin == s1.bin);
      cleared  <= s1_valid && s1.eot;
      if (s1_valid && s1.eot) seen <= '0;
      else if (wr_en)         seen[s1.bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) s1 <= q_head;
  end

  // leader state, back to reset after each text
  always_ff @(posedge clk) begin
    if (rst) begin
      best_letter <= '0;
      best_count  <= '0;
      best_rank   <= '0;
      next_rank   <= RANK_W'(1);
    end else if (adv && s1_valid) begin
      if (s1.eot) begin
        best_letter <= '0;
        best_count  <= '0;
        best_rank   <= '0;
        next_rank   <= RANK_W'(1);
      end else begin
        best_letter <= best_letter_next;
        best_count  <= best_count_next;
        best_rank   <= best_rank_next;
        next_rank   <= next_rank_next;
      end
    end
  end

  // result register
  assign take_out = adv && s1_valid && s1.eot;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      letter_found <= (best_count_next != '0);
      top_letter   <= best_letter_next;
      top_count    <= TOP_CNT_W'(best_count_next);
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfl_pkg::*;

  // one reported mode of a text
  typedef struct packed {
    logic [CHAR_W-1:0]    letter;
    logic [TOP_CNT_W-1:0] count;
    logic                 found;
  } mode_t;

  // one directed transfer, with the mode typed in where it is obvious
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              eot;
    logic              typed;
    mode_t             want;
  } dir_row_t;

  localparam mode_t NO_MODE = '{8'h00, 11'd0, 1'b0};
  localparam int N_DIR = 23;
  localparam int HOLD_CYCLES = 60;
  localparam int N_ITEMS = 1850;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{8'h00, 1'b1, 1'b1, NO_MODE},                   // empty text, low byte
    '{8'hff, 1'b1, 1'b1, NO_MODE},                   // empty text, high byte
    '{8'h41, 1'b1, 1'b1, '{8'h41, 11'd1, 1'b1}},     // 'A' alone
    '{8'h7a, 1'b1, 1'b1, '{8'h7a, 11'd1, 1'b1}},     // 'z' alone
    '{8'h40, 1'b0, 1'b0, NO_MODE},                   // bytes just outside both ranges
    '{8'h5b, 1'b0, 1'b0, NO_MODE},
    '{8'h60, 1'b0, 1'b0, NO_MODE},
    '{8'h7b, 1'b1, 1'b1, NO_MODE},
    '{8'h5a, 1'b0, 1'b0, NO_MODE},                   // 'Z' then 'a': tie, first wins
    '{8'h61, 1'b1, 1'b1, '{8'h5a, 11'd1, 1'b1}},
    '{8'h6b, 1'b0, 1'b0, NO_MODE},                   // case-sensitive bins
    '{8'h4b, 1'b1, 1'b1, '{8'h6b, 11'd1, 1'b1}},
    '{8'h62, 1'b0, 1'b0, NO_MODE},                   // "bccb": tie at two
    '{8'h63, 1'b0, 1'b0, NO_MODE},
    '{8'h63, 1'b0, 1'b0, NO_MODE},
    '{8'h62, 1'b1, 1'b1, '{8'h62, 11'd2, 1'b1}},
    '{8'h4d, 1'b0, 1'b0, NO_MODE},                   // non-letter on the last byte
    '{8'h80, 1'b1, 1'b1, '{8'h4d, 11'd1, 1'b1}},
    '{8'h71, 1'b0, 1'b0, NO_MODE},                   // later letter overtakes
    '{8'h72, 1'b0, 1'b0, NO_MODE},
    '{8'h72, 1'b0, 1'b0, NO_MODE},
    '{8'h71, 1'b0, 1'b0, NO_MODE},
    '{8'h72, 1'b1, 1'b0, NO_MODE}
  };

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [CHAR_W-1:0]    char_code;
  logic                 end_of_text;
  logic                 out_valid;
  logic                 out_stall;
  logic [CHAR_W-1:0]    top_letter;
  logic [TOP_CNT_W-1:0] top_count;
  logic                 letter_found;

  // histogram predictor state
  logic [CNT_W-1:0]  hist_cnt  [NUM_BINS];
  logic [RANK_W-1:0] hist_rank [NUM_BINS];
  logic [RANK_W-1:0] rank_next;
  logic [CHAR_W-1:0] lead_code;
  logic [CNT_W-1:0]  lead_cnt;
  logic [RANK_W-1:0] lead_rank;

  mode_t pending_modes [$];
  int    fail_count;
  int    sent_count;
  bit    gaps_on;
  bit    stalls_on;
  bit    hold_req;

  most_frequent_letter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .top_letter   (top_letter),
    .top_count    (top_count),
    .letter_found (letter_found)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bin of a letter, -1 for any other byte
  function automatic int letter_bin(input logic [CHAR_W-1:0] c);
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) return int'(c) - int'(CHAR_UP_A);
    if (c >= CHAR_LO_A && c <= CHAR_LO_Z) return int'(c) - int'(CHAR_LO_A) + 26;
    return -1;
  endfunction

  function automatic logic [CHAR_W-1:0] letter_of(input int b);
    if (b < 26) return CHAR_UP_A + CHAR_W'(b);
    return CHAR_LO_A + CHAR_W'(b - 26);
  endfunction

  function automatic logic [CHAR_W-1:0] other_byte();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255)); while (letter_bin(c) >= 0);
    return c;
  endfunction

  function automatic void clear_hist();
    for (int i = 0; i < NUM_BINS; i++) begin
      hist_cnt[i]  = '0;
      hist_rank[i] = '0;
    end
    rank_next = RANK_W'(1);
    lead_code = '0;
    lead_cnt  = '0;
    lead_rank = '0;
  endfunction

  // count one byte; on end of text give the mode and start over
  function automatic bit count_letter(input logic [CHAR_W-1:0] c, input logic eot,
                                      output mode_t mode);
    int b;
    b = letter_bin(c);
    if (b >= 0) begin
      if (hist_rank[b] == '0) begin
        hist_rank[b] = rank_next;
        rank_next    = rank_next + RANK_W'(1);
      end
      if (hist_cnt[b] < MAX_LEN) hist_cnt[b] = hist_cnt[b] + CNT_W'(1);
      if (hist_cnt[b] > lead_cnt ||
          (hist_cnt[b] == lead_cnt && hist_rank[b] < lead_rank)) begin
        lead_cnt  = hist_cnt[b];
        lead_rank = hist_rank[b];
        lead_code = c;
      end
    end
    mode = NO_MODE;
    if (!eot) return 1'b0;
    if (lead_cnt != '0) mode = '{lead_code, TOP_CNT_W'(lead_cnt), 1'b1};
    clear_hist();
    return 1'b1;
  endfunction

  // offer one byte and wait for its transfer
  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eot,
                           input logic typed, input mode_t want);
    mode_t mode;
    bit    done;
    char_code   <= c;
    end_of_text <= eot;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    done = count_letter(c, eot, mode);
    if (done) pending_modes.push_back(typed ? want : mode);
    sent_count++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // text drawn mostly from a few letters, so counts climb and tie
  task automatic send_pool_text(input int max_len);
    int pool [6];
    int npool;
    int len;
    int r;
    logic [CHAR_W-1:0] c;
    len   = $urandom_range(1, max_len);
    npool = $urandom_range(1, 6);
    for (int i = 0; i < npool; i++) pool[i] = $urandom_range(0, NUM_BINS - 1);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 19);
      if (r < 17) c = letter_of(pool[$urandom_range(0, npool - 1)]);
      else if (r < 19) c = letter_of($urandom_range(0, NUM_BINS - 1));
      else c = other_byte();
      send_byte(c, i == len - 1, 1'b0, NO_MODE);
    end
  endtask

  // every letter once in shuffled order, then a few repeats
  task automatic send_alphabet_text();
    int ord [NUM_BINS];
    int j;
    int t;
    int extra;
    extra = $urandom_range(0, 8);
    for (int i = 0; i < NUM_BINS; i++) ord[i] = i;
    for (int i = NUM_BINS - 1; i > 0; i--) begin
      j      = $urandom_range(0, i);
      t      = ord[i];
      ord[i] = ord[j];
      ord[j] = t;
    end
    for (int i = 0; i < NUM_BINS; i++)
      send_byte(letter_of(ord[i]), extra == 0 && i == NUM_BINS - 1, 1'b0, NO_MODE);
    for (int i = 0; i < extra; i++)
      send_byte(letter_of(ord[$urandom_range(0, 9)]), i == extra - 1, 1'b0, NO_MODE);
  endtask

  task automatic send_letterless_text();
    int len;
    len = $urandom_range(1, 5);
    for (int i = 0; i < len; i++) send_byte(other_byte(), i == len - 1, 1'b0, NO_MODE);
  endtask

  // one letter driven well past the count limit
  task automatic send_saturating_text();
    logic [CHAR_W-1:0] heavy;
    heavy = letter_of($urandom_range(0, NUM_BINS - 1));
    send_byte(letter_of($urandom_range(0, NUM_BINS - 1)), 1'b0, 1'b0, NO_MODE);
    for (int i = 0; i < MAX_LEN + 6; i++) begin
      if (i % 97 == 50) send_byte(letter_of($urandom_range(0, NUM_BINS - 1)), 1'b0, 1'b0, NO_MODE);
      send_byte(heavy, i == MAX_LEN + 5, 1'b0, NO_MODE);
    end
  endtask

  task automatic send_random_mix();
    case ($urandom_range(0, 19))
      0:       send_alphabet_text();
      1:       send_letterless_text();
      2, 3:    send_byte(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                         1'b0, NO_MODE);
      default: send_pool_text(20);
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_modes.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    repeat (10) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  initial begin
    mode_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_modes.size() == 0) begin
          $error("result transfer with none expected: letter %0h count %0d found %0b",
                 top_letter, top_count, letter_found);
          fail_count++;
        end else begin
          want = pending_modes.pop_front();
          if (top_letter !== want.letter) begin
            $error("top_letter: expected %0h, actual %0h", want.letter, top_letter);
            fail_count++;
          end
          if (top_count !== want.count) begin
            $error("top_count: expected %0d, actual %0d", want.count, top_count);
            fail_count++;
          end
          if (letter_found !== want.found) begin
            $error("letter_found: expected %0b, actual %0b", want.found, letter_found);
            fail_count++;
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    char_code   = '0;
    end_of_text = 1'b0;
    out_stall   = 1'b0;
    fail_count  = 0;
    sent_count  = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    hold_req    = 1'b0;
    clear_hist();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_byte(DIR_ROWS[i].code, DIR_ROWS[i].eot, DIR_ROWS[i].typed, DIR_ROWS[i].want);

    while (sent_count < 550) send_random_mix();

    // long receiver hold while short texts keep coming back to back
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (25) send_pool_text(4);
    gaps_on = 1'b1;

    // sender pause until every mode is back
    drain_results();
    repeat (5) @(posedge clk);

    send_saturating_text();

    // closing stretch with no idling on either side
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (sent_count < N_ITEMS) send_random_mix();

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
